// File: rtl/pit_pkg.sv
// Shared types and constants for the point-in-tetrahedron test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pit_pkg;

   localparam int COORD_W   = 16;               // coordinate width, at most FIELD_W
   localparam int FIELD_W   = 16;               // point field port width
   localparam int CORNER_W  = 48;               // corner register port width
   localparam int ADDR_W    = 3;
   localparam int VERT_W    = 3 * COORD_W;      // packed x, y, z
   localparam int DIF_W     = COORD_W + 1;      // edge vector component
   localparam int NRM_W     = 2 * COORD_W + 2;  // face normal component
   localparam int PRD_W     = DIF_W + NRM_W;    // setup multiplier product
   localparam int PPRD_W    = COORD_W + NRM_W;  // stream multiplier product
   localparam int ACC_W     = 3 * COORD_W + 5;  // face offset and affine sum
   localparam int NUM_FACES = 4;
   localparam int FACE_W    = 2;
   localparam logic [FACE_W-1:0] FACE_LAST = FACE_W'(NUM_FACES - 1);

   typedef enum logic [ADDR_W-1:0] {
      CSR_CORNER_A = 3'd0,
      CSR_CORNER_B = 3'd1,
      CSR_CORNER_C = 3'd2,
      CSR_CORNER_D = 3'd3
   } csr_addr_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // setup micro-steps: normal (two per component), offset, reference check
   typedef enum logic [3:0] {
      STEP_NX0, STEP_NX1, STEP_NY0, STEP_NY1, STEP_NZ0, STEP_NZ1,
      STEP_K0,  STEP_K1,  STEP_K2,  STEP_R0,  STEP_R1,  STEP_R2
   } step_type;

   // D(p) = p . n + k for one face
   typedef struct packed {
      logic signed [ACC_W-1:0] k;
      logic signed [NRM_W-1:0] nz;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nx;
   } face_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   function automatic logic signed [DIF_W-1:0] coord(input logic [VERT_W-1:0] w,
                                                     input logic [1:0] idx);
      logic signed [COORD_W-1:0] c;
      c = $signed(w[int'(idx) * COORD_W +: COORD_W]);
      return DIF_W'(c);
   endfunction

endpackage
`default_nettype wire

// File: rtl/pit_setup.sv
// Corner registers and the face-plane setup sequencer (one shared MAC).
// Depends on pit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pit_setup
   import pit_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [ADDR_W-1:0]   csr_addr,
   input  wire logic [CORNER_W-1:0] csr_wdata,
   output logic                     busy,
   output face_type                 faces [NUM_FACES],
   output sign_type                 ref_sign
);

   logic [VERT_W-1:0] corner_ff [NUM_FACES];
   seq_state_type     state_ff, state_in;
   logic [FACE_W-1:0] face_ff, face_in;
   step_type          step_ff, step_in;
   face_type          faces_ff [NUM_FACES];
   sign_type          ref_ff;

   logic signed [NRM_W-1:0] wn_ff [3];
   logic signed [ACC_W-1:0] wk_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic wr_hit, run_en;
   logic [VERT_W-1:0] vp, vq, vr, vv;
   logic signed [DIF_W-1:0] e1 [3];
   logic signed [DIF_W-1:0] e2 [3];
   logic signed [DIF_W-1:0] op_a;
   logic signed [NRM_W-1:0] op_b;
   logic signed [PRD_W-1:0] prod;
   logic signed [ACC_W-1:0] base;
   logic                    sub;
   logic signed [NRM_W-1:0] nrm_in;

   always_comb begin
      unique case (csr_addr_type'(csr_addr))
         CSR_CORNER_A, CSR_CORNER_B, CSR_CORNER_C, CSR_CORNER_D: wr_hit = csr_valid;
         default: wr_hit = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (wr_hit) state_in = SEQ_RUN;
         SEQ_RUN: begin
            if (!wr_hit && step_ff == STEP_R2 && face_ff == FACE_LAST) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      busy   = (state_ff == SEQ_RUN);
      run_en = busy && !wr_hit;
   end

   always_comb begin
      face_in = face_ff;
      step_in = step_ff;
      if (wr_hit) begin
         face_in = '0;
         step_in = STEP_NX0;
      end else if (busy) begin
         if (step_ff == STEP_R2) begin
            step_in = STEP_NX0;
            face_in = face_ff + FACE_W'(1);
         end else begin
            step_in = step_type'(step_ff + 4'd1);
         end
      end
   end

   // the three other corners of the face, in ascending order, and its own corner
   always_comb begin
      case (face_ff)
         2'd0:    begin vp = corner_ff[1]; vq = corner_ff[2]; vr = corner_ff[3]; vv = corner_ff[0]; end
         2'd1:    begin vp = corner_ff[0]; vq = corner_ff[2]; vr = corner_ff[3]; vv = corner_ff[1]; end
         2'd2:    begin vp = corner_ff[0]; vq = corner_ff[1]; vr = corner_ff[3]; vv = corner_ff[2]; end
         default: begin vp = corner_ff[0]; vq = corner_ff[1]; vr = corner_ff[2]; vv = corner_ff[3]; end
      endcase
      for (int c = 0; c < 3; c++) begin
         e1[c] = coord(vq, 2'(c)) - coord(vp, 2'(c));
         e2[c] = coord(vr, 2'(c)) - coord(vp, 2'(c));
      end
   end

   // MAC operand selection
   always_comb begin
      op_a = '0;
      op_b = '0;
      base = '0;
      sub  = 1'b0;
      case (step_ff)
         STEP_NX0: begin op_a = e1[1]; op_b = NRM_W'(e2[2]); end
         STEP_NX1: begin op_a = e1[2]; op_b = NRM_W'(e2[1]); base = acc_ff; sub = 1'b1; end
         STEP_NY0: begin op_a = e1[2]; op_b = NRM_W'(e2[0]); end
         STEP_NY1: begin op_a = e1[0]; op_b = NRM_W'(e2[2]); base = acc_ff; sub = 1'b1; end
         STEP_NZ0: begin op_a = e1[0]; op_b = NRM_W'(e2[1]); end
         STEP_NZ1: begin op_a = e1[1]; op_b = NRM_W'(e2[0]); base = acc_ff; sub = 1'b1; end
         STEP_K0:  begin op_a = coord(vp, 2'd0); op_b = wn_ff[0]; sub = 1'b1; end
         STEP_K1:  begin op_a = coord(vp, 2'd1); op_b = wn_ff[1]; base = acc_ff; sub = 1'b1; end
         STEP_K2:  begin op_a = coord(vp, 2'd2); op_b = wn_ff[2]; base = acc_ff; sub = 1'b1; end
         STEP_R0:  begin op_a = coord(vv, 2'd0); op_b = wn_ff[0]; base = wk_ff; end
         STEP_R1:  begin op_a = coord(vv, 2'd1); op_b = wn_ff[1]; base = acc_ff; end
         STEP_R2:  begin op_a = coord(vv, 2'd2); op_b = wn_ff[2]; base = acc_ff; end
         default:  begin op_a = '0; op_b = '0; end
      endcase
      prod   = op_a * op_b;
      acc_in = sub ? (base - ACC_W'(prod)) : (base + ACC_W'(prod));
      // odd faces carry the opposite sign
      nrm_in = face_ff[0] ? NRM_W'(-acc_in) : NRM_W'(acc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         face_ff  <= '0;
         step_ff  <= STEP_NX0;
         ref_ff   <= '0;
         for (int f = 0; f < NUM_FACES; f++) begin
            corner_ff[f] <= '0;
            faces_ff[f]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         face_ff  <= face_in;
         step_ff  <= step_in;
         if (wr_hit) corner_ff[csr_addr[1:0]] <= csr_wdata[VERT_W-1:0];
         if (run_en && step_ff == STEP_K2) begin
            faces_ff[face_ff] <= '{k: acc_in, nz: wn_ff[2], ny: wn_ff[1], nx: wn_ff[0]};
         end
         if (run_en && step_ff == STEP_R2 && face_ff == '0) begin
            ref_ff <= '{pos: !acc_in[ACC_W-1] && (acc_in != '0), neg: acc_in[ACC_W-1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (run_en) begin
         case (step_ff)
            STEP_NX1: wn_ff[0] <= nrm_in;
            STEP_NY1: wn_ff[1] <= nrm_in;
            STEP_NZ1: wn_ff[2] <= nrm_in;
            STEP_K2:  wk_ff    <= acc_in;
            default:  ;
         endcase
      end
   end

   assign faces    = faces_ff;
   assign ref_sign = ref_ff;

endmodule
`default_nettype wire

// File: rtl/pit_pipe.sv
// Four-stage streaming evaluation of the face sums with per-stage valid bits.
// Depends on pit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pit_pipe
   import pit_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       hold,
   input  wire logic                       in_valid,
   output logic                            in_stall,
   input  wire logic signed [COORD_W-1:0]  in_x,
   input  wire logic signed [COORD_W-1:0]  in_y,
   input  wire logic signed [COORD_W-1:0]  in_z,
   input  wire face_type                   faces [NUM_FACES],
   input  wire sign_type                   ref_sign,
   output logic                            out_valid,
   input  wire logic                       out_stall,
   output logic                            out_inside,
   output logic                            out_degen
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4, accept;

   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [PPRD_W-1:0]  mx_ff [NUM_FACES];
   logic signed [PPRD_W-1:0]  my_ff [NUM_FACES];
   logic signed [PPRD_W-1:0]  mz_ff [NUM_FACES];
   logic signed [ACC_W-1:0]   sa_ff [NUM_FACES];
   logic signed [ACC_W-1:0]   sb_ff [NUM_FACES];
   logic signed [ACC_W-1:0]   sum   [NUM_FACES];
   logic [NUM_FACES-1:0]      ok;
   logic inside_ff, degen_ff;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      en4      = !v4_ff || !out_stall;
      en3      = !v3_ff || en4;
      en2      = !v2_ff || en3;
      en1      = !v1_ff || en2;
      in_stall = hold || !en1;
      accept   = in_valid && !in_stall;
   end

   always_comb begin
      for (int f = 0; f < NUM_FACES; f++) begin
         sum[f] = sa_ff[f] + sb_ff[f];
         ok[f]  = !((!sum[f][ACC_W-1] && sum[f] != '0 && ref_sign.neg) ||
                    (sum[f][ACC_W-1] && ref_sign.pos));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px_ff <= in_x;
         py_ff <= in_y;
         pz_ff <= in_z;
      end
      for (int f = 0; f < NUM_FACES; f++) begin
         if (en2) begin
            mx_ff[f] <= px_ff * $signed(faces[f].nx);
            my_ff[f] <= py_ff * $signed(faces[f].ny);
            mz_ff[f] <= pz_ff * $signed(faces[f].nz);
         end
         if (en3) begin
            sa_ff[f] <= ACC_W'(mx_ff[f]) + ACC_W'(my_ff[f]);
            sb_ff[f] <= ACC_W'(mz_ff[f]) + $signed(faces[f].k);
         end
      end
      if (en4) begin
         degen_ff  <= !ref_sign.pos && !ref_sign.neg;
         inside_ff <= (ref_sign.pos || ref_sign.neg) && (&ok);
      end
   end

   assign out_valid  = v4_ff;
   assign out_inside = inside_ff;
   assign out_degen  = degen_ff;

endmodule
`default_nettype wire

// File: rtl/point_in_tetrahedron_test.sv
// Top level of the point-in-tetrahedron test: corner setup plus stream pipeline.
// Depends on pit_pkg, pit_setup and pit_pipe.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_point_x, req_point_y, req_point_z
//   rsp     | out       | rsp_valid/rsp_stall | rsp_inside_res, rsp_degenerate
//   csr     | in        | csr_valid/csr_ready | csr_addr, csr_wdata (corner a..d)
//
// One request per cycle while req_stall is low, through four register stages; rsp_valid
// rises when the request has reached the fourth stage.
// A corner write starts a recompute (4 faces x 12 steps of the single
// setup multiply-accumulate); req_stall is high during it. csr_ready is always high.
// Reset clears corners, face planes and the reference sign (degenerate answer).
// rsp_stall freezes only the stages that are full; bubbles close up.
`timescale 1ns / 1ps
`default_nettype none
module point_in_tetrahedron_test
   import pit_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [FIELD_W-1:0]  req_point_x,
   input  wire logic signed [FIELD_W-1:0]  req_point_y,
   input  wire logic signed [FIELD_W-1:0]  req_point_z,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_inside_res,
   output logic                            rsp_degenerate,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [ADDR_W-1:0]          csr_addr,
   input  wire logic [CORNER_W-1:0]        csr_wdata
);

   logic     busy;
   face_type faces [NUM_FACES];
   sign_type ref_sign;

   assign csr_ready = 1'b1;

   pit_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .faces     (faces),
      .ref_sign  (ref_sign)
   );

   // only the low COORD_W bits of each coordinate count
   pit_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .hold       (busy),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_x       (req_point_x[COORD_W-1:0]),
      .in_y       (req_point_y[COORD_W-1:0]),
      .in_z       (req_point_z[COORD_W-1:0]),
      .faces      (faces),
      .ref_sign   (ref_sign),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_inside (rsp_inside_res),
      .out_degen  (rsp_degenerate)
   );

endmodule
`default_nettype wire

// File: rtl/pit_checker.sv
// Port-level checks for point_in_tetrahedron_test, bound to the top level.
// Depends on pit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pit_checker
   import pit_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_inside_res,
   input wire logic                rsp_degenerate,
   input wire logic                csr_valid,
   input wire logic                csr_ready,
   input wire logic [ADDR_W-1:0]   csr_addr
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_degen_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_inside_res)
      else $error("degenerate response marked inside");

   a_setup_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_addr == CSR_CORNER_A || csr_addr == CSR_CORNER_B ||
                                 csr_addr == CSR_CORNER_C || csr_addr == CSR_CORNER_D)
      |=> req_stall)
      else $error("request taken during face recompute");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind point_in_tetrahedron_test pit_checker u_pit_checker (.*);
`default_nettype wire
